>>> hdl/lacm_pkg.sv
// ----------------------------------------------------------------------------
// lacm_pkg: shared types and constants of the look-at camera matrix block
// Widths, item and row records, control groups and state encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lacm_pkg;

  localparam int DIR_W       = 16;
  localparam int POS_W       = 24;
  localparam int TR_W        = 25;
  localparam int IN_W        = 120;
  localparam int OUT_W       = 80;
  localparam int QUEUE_DEPTH = 2;

  // normalizer widths
  localparam int VEC_W  = 32;  // signed vector component into the normalizer
  localparam int MAG_W  = 31;  // |v| << k never exceeds the root
  localparam int SQ_W   = 62;  // sum of squares, below 2^62
  localparam int NUM_W  = 46;  // (|v| << (14+k)) + root/2
  localparam int QUO_W  = 15;  // quotient magnitude, at most 2^14

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_DIR  = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  localparam logic signed [TR_W-1:0] T_ONE = 25'sd4096;

  // output word layout
  localparam int O_IDX_LSB = 0;
  localparam int O_C0_LSB  = 2;
  localparam int O_C3_LSB  = 50;
  localparam int O_C3_MSB  = 74;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    flat;   // direction has no x/z part
  } item_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [DIR_W-1:0] col_zero;
    logic signed [DIR_W-1:0] col_one;
    logic signed [DIR_W-1:0] col_two;
    logic signed [TR_W-1:0]  col_three;
    logic                    last_row;
    logic                    degenerate;
  } row_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] v0;
    logic signed [VEC_W-1:0] v1;
    logic signed [VEC_W-1:0] v2;
  } norm_req_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic signed [DIR_W-1:0] o0;
    logic signed [DIR_W-1:0] o1;
    logic signed [DIR_W-1:0] o2;
  } norm_rsp_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_SCALE, N_ROOT, N_DIVSET, N_DIV
  } norm_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_SIDE, B_CROSS, B_UP, B_TPROD, B_TSUM, B_TRND, B_FIN
  } back_state_e;

endpackage

`default_nettype wire

>>> hdl/lacm_front.sv
// ----------------------------------------------------------------------------
// lacm_front: input register and classifier
// Take a word, flag a direction with no x/z part, hand it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lacm_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_valid_i,
  output logic                              s_ready_o,
  input  wire logic [lacm_pkg::IN_W-1:0]    s_data_i,
  output logic                              push_o,
  output lacm_pkg::item_t                   item_o,
  input  wire logic                         q_ready_i
);

  logic            valid_q, valid_d;
  lacm_pkg::item_t item_q;
  lacm_pkg::item_t item_d;

  assign s_ready_o = !valid_q || q_ready_i;
  assign push_o    = valid_q && q_ready_i;
  assign item_o    = item_q;

  always_comb begin
    item_d.dir_x = s_data_i[15:0];
    item_d.dir_y = s_data_i[31:16];
    item_d.dir_z = s_data_i[47:32];
    item_d.pos_x = s_data_i[71:48];
    item_d.pos_y = s_data_i[95:72];
    item_d.pos_z = s_data_i[119:96];
    item_d.flat  = (s_data_i[15:0] == '0) && (s_data_i[47:32] == '0);
  end

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lacm_queue.sv
// ----------------------------------------------------------------------------
// lacm_queue: short item queue between front and back
// Circular buffer with a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lacm_queue #(
  parameter int Depth = lacm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lacm_pkg::item_t  item_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output lacm_pkg::item_t       item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  lacm_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lacm_norm.sv
// ----------------------------------------------------------------------------
// lacm_norm: iterative vector normalizer
// Sum of squares, scale by four until the top pair is reached, bit-pair
// square root, then one restoring divide per component.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lacm_norm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lacm_pkg::norm_req_t req_i,
  output lacm_pkg::norm_rsp_t      rsp_o
);

  localparam int MagW  = lacm_pkg::MAG_W;
  localparam int SqW   = lacm_pkg::SQ_W;
  localparam int NumW  = lacm_pkg::NUM_W;
  localparam int QuoW  = lacm_pkg::QUO_W;
  localparam int DirW  = lacm_pkg::DIR_W;
  localparam int LastSq   = 3;
  localparam int LastRoot = SqW / 2 - 1;
  localparam int LastDiv  = QuoW - 1;

  lacm_pkg::norm_state_e state_q, state_d;

  logic [MagW-1:0]   mag_q [3];
  logic              neg_q [3];
  logic [SqW-1:0]    sum_q, prod_q, sum_nx, rem_q;
  logic [SqW-1:0]    root_q;
  logic [SqW-2:0]    bit_q;
  logic [SqW:0]      rb;
  logic              root_ge;
  logic [4:0]        cnt_q;
  logic [1:0]        sel_q;
  logic [NumW-1:0]   num_q, den_q;
  logic              div_ge;
  logic [QuoW-1:0]   quo_q, quo_nx;
  logic signed [DirW-1:0] o_q [3];
  logic              done_q, zero_q;
  logic              sq_last, fin_zero, div_last, fin_ok;
  logic signed [lacm_pkg::VEC_W-1:0] vin [3];
  logic [MagW-1:0]   sq_op;
  logic [SqW-1:0]    sq_full;

  assign vin[0] = req_i.v0;
  assign vin[1] = req_i.v1;
  assign vin[2] = req_i.v2;

  // full-width square of the selected component
  assign sq_op   = mag_q[cnt_q[1:0]];
  assign sq_full = sq_op * sq_op;

  assign sum_nx  = sum_q + ((cnt_q != '0) ? prod_q : '0);
  assign rb      = {1'b0, root_q} + {2'b00, bit_q};
  assign root_ge = ({1'b0, rem_q} >= rb);
  assign div_ge  = (num_q >= den_q);
  assign quo_nx  = {quo_q[QuoW-2:0], div_ge};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lacm_pkg::N_IDLE: begin
        if (req_i.start) state_d = lacm_pkg::N_SQ;
      end
      lacm_pkg::N_SQ: begin
        if (cnt_q == 5'(LastSq)) begin
          state_d = (sum_nx == '0) ? lacm_pkg::N_IDLE : lacm_pkg::N_SCALE;
        end
      end
      lacm_pkg::N_SCALE: begin
        if (sum_q[SqW-1:SqW-2] != 2'b00) state_d = lacm_pkg::N_ROOT;
      end
      lacm_pkg::N_ROOT: begin
        if (cnt_q == 5'(LastRoot)) state_d = lacm_pkg::N_DIVSET;
      end
      lacm_pkg::N_DIVSET: begin
        state_d = lacm_pkg::N_DIV;
      end
      lacm_pkg::N_DIV: begin
        if (cnt_q == 5'(LastDiv)) begin
          state_d = (sel_q == 2'd2) ? lacm_pkg::N_IDLE : lacm_pkg::N_DIVSET;
        end
      end
      default: state_d = lacm_pkg::N_IDLE;
    endcase
  end

  // decoded controls
  always_comb begin
    sq_last  = (state_q == lacm_pkg::N_SQ) && (cnt_q == 5'(LastSq));
    fin_zero = sq_last && (sum_nx == '0);
    div_last = (state_q == lacm_pkg::N_DIV) && (cnt_q == 5'(LastDiv));
    fin_ok   = div_last && (sel_q == 2'd2);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;
  assign rsp_o.o0   = o_q[0];
  assign rsp_o.o1   = o_q[1];
  assign rsp_o.o2   = o_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lacm_pkg::N_IDLE;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin_ok || fin_zero;
      if (fin_ok || fin_zero) zero_q <= fin_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lacm_pkg::N_IDLE: begin
        if (req_i.start) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vin[i][lacm_pkg::VEC_W-1];
            mag_q[i] <= MagW'(vin[i][lacm_pkg::VEC_W-1] ? -vin[i] : vin[i]);
          end
          sum_q <= '0;
          cnt_q <= '0;
        end
      end
      lacm_pkg::N_SQ: begin
        if (cnt_q != 5'(LastSq)) begin
          prod_q <= sq_full;
        end
        sum_q <= sum_nx;
        cnt_q <= cnt_q + 1'b1;
      end
      lacm_pkg::N_SCALE: begin
        if (sum_q[SqW-1:SqW-2] == 2'b00) begin
          // scale by four, track the half shift on each component
          sum_q <= {sum_q[SqW-3:0], 2'b00};
          for (int i = 0; i < 3; i++) mag_q[i] <= {mag_q[i][MagW-2:0], 1'b0};
        end else begin
          rem_q  <= sum_q;
          root_q <= '0;
          bit_q  <= {1'b1, {(SqW-2){1'b0}}};
          cnt_q  <= '0;
        end
      end
      lacm_pkg::N_ROOT: begin
        if (root_ge) begin
          rem_q  <= rem_q - SqW'(rb);
          root_q <= (root_q >> 1) + SqW'(bit_q);
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
        sel_q <= '0;
      end
      lacm_pkg::N_DIVSET: begin
        // numerator carries the half divisor for round-half-up on magnitude
        num_q <= NumW'({mag_q[sel_q], 14'b0}) + NumW'(root_q[MagW-1:1]);
        den_q <= NumW'({root_q[MagW-1:0], 14'b0});
        quo_q <= '0;
        cnt_q <= '0;
      end
      lacm_pkg::N_DIV: begin
        if (div_ge) num_q <= num_q - den_q;
        den_q <= den_q >> 1;
        quo_q <= quo_nx;
        cnt_q <= cnt_q + 1'b1;
        if (div_last) begin
          o_q[sel_q] <= neg_q[sel_q] ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
          sel_q <= sel_q + 1'b1;
        end
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/lacm_back.sv
// ----------------------------------------------------------------------------
// lacm_back: matrix sequencer and row emitter
// Pop an item, build side, up and translation terms, then emit four rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lacm_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire lacm_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output lacm_pkg::row_t       m_row_o
);

  localparam int DirW = lacm_pkg::DIR_W;
  localparam int PosW = lacm_pkg::POS_W;
  localparam int TrW  = lacm_pkg::TR_W;
  localparam int PrW  = DirW + 1 + PosW;   // row entry times position
  localparam int AccW = PrW + 2;

  function automatic logic signed [DirW-1:0] sat_neg(input logic signed [DirW-1:0] v);
    logic signed [DirW:0] n;
    n = -{v[DirW-1], v};
    sat_neg = (n[DirW] != n[DirW-1]) ? {1'b0, {(DirW-1){1'b1}}} : n[DirW-1:0];
  endfunction

  function automatic logic signed [TrW-1:0] round_sat(input logic signed [AccW-1:0] a);
    logic [AccW-1:0]    mag;
    logic [AccW-15:0]   q;
    logic               ovf;
    mag = a[AccW-1] ? AccW'(-a) : AccW'(a);
    q   = (AccW-14)'((mag + AccW'(8192)) >> 14);
    ovf = a[AccW-1] ? (q > (AccW-14)'(1 << (TrW - 1)))
                    : (q > (AccW-14)'((1 << (TrW - 1)) - 1));
    if (ovf) begin
      round_sat = a[AccW-1] ? {1'b1, {(TrW-1){1'b0}}} : {1'b0, {(TrW-1){1'b1}}};
    end else begin
      round_sat = a[AccW-1] ? -$signed(q[TrW-1:0]) : $signed(q[TrW-1:0]);
    end
  endfunction

  lacm_pkg::back_state_e state_q, state_d;
  lacm_pkg::norm_req_t   nreq;
  lacm_pkg::norm_rsp_t   nrsp;

  logic signed [DirW-1:0] d_q [3];
  logic signed [PosW-1:0] p_q [3];
  logic signed [DirW-1:0] s_q [3];
  logic signed [DirW-1:0] u_q [3];
  logic signed [lacm_pkg::VEC_W-1:0] uv_q [3];
  logic signed [2*DirW-1:0] pa_q, pb_q;
  logic signed [DirW-1:0] ma1, mb1, ma2, mb2;
  logic [1:0]             cnt_q;
  logic                   deg_q;
  logic signed [PrW-1:0]  tp_q [3];
  logic signed [DirW:0]   rv [3];
  logic signed [AccW-1:0] acc_q;
  logic signed [TrW-1:0]  t_q [3];
  logic                   load;
  lacm_pkg::row_t         ebuf_q [4];
  logic                   ebusy_q;
  logic [1:0]             ecnt_q;

  lacm_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  // cross product operand selection: uv[c] = s[c+1]*d[c+2] - s[c+2]*d[c+1]
  always_comb begin
    case (cnt_q)
      2'd0: begin ma1 = s_q[1]; mb1 = d_q[2]; ma2 = s_q[2]; mb2 = d_q[1]; end
      2'd1: begin ma1 = s_q[2]; mb1 = d_q[0]; ma2 = s_q[0]; mb2 = d_q[2]; end
      default: begin ma1 = s_q[0]; mb1 = d_q[1]; ma2 = s_q[1]; mb2 = d_q[0]; end
    endcase
  end

  // translation row vector: side, up or the exact negated direction
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      case (cnt_q)
        lacm_pkg::ROW_SIDE: rv[j] = {s_q[j][DirW-1], s_q[j]};
        lacm_pkg::ROW_UP:   rv[j] = {u_q[j][DirW-1], u_q[j]};
        default:            rv[j] = -{d_q[j][DirW-1], d_q[j]};
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lacm_pkg::B_IDLE: begin
        if (q_valid_i) state_d = q_item_i.flat ? lacm_pkg::B_FIN : lacm_pkg::B_SIDE;
      end
      lacm_pkg::B_SIDE: begin
        if (nrsp.done) state_d = lacm_pkg::B_CROSS;
      end
      lacm_pkg::B_CROSS: begin
        if (cnt_q == 2'd3) state_d = lacm_pkg::B_UP;
      end
      lacm_pkg::B_UP: begin
        if (nrsp.done) state_d = nrsp.zero ? lacm_pkg::B_FIN : lacm_pkg::B_TPROD;
      end
      lacm_pkg::B_TPROD: state_d = lacm_pkg::B_TSUM;
      lacm_pkg::B_TSUM:  state_d = lacm_pkg::B_TRND;
      lacm_pkg::B_TRND: begin
        state_d = (cnt_q == lacm_pkg::ROW_DIR) ? lacm_pkg::B_FIN : lacm_pkg::B_TPROD;
      end
      lacm_pkg::B_FIN: begin
        if (!ebusy_q) state_d = lacm_pkg::B_IDLE;
      end
      default: state_d = lacm_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop_o    = (state_q == lacm_pkg::B_IDLE) && q_valid_i;
    load       = (state_q == lacm_pkg::B_FIN) && !ebusy_q;
    nreq.start = 1'b0;
    nreq.v0    = -lacm_pkg::VEC_W'(q_item_i.dir_z);
    nreq.v1    = '0;
    nreq.v2    = lacm_pkg::VEC_W'(q_item_i.dir_x);
    if (state_q == lacm_pkg::B_IDLE) begin
      nreq.start = q_valid_i && !q_item_i.flat;
    end else if (state_q == lacm_pkg::B_CROSS) begin
      nreq.start = (cnt_q == 2'd3);
      nreq.v0    = uv_q[0];
      nreq.v1    = uv_q[1];
      nreq.v2    = lacm_pkg::VEC_W'(pa_q - pb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lacm_pkg::B_IDLE;
      ebusy_q <= 1'b0;
      ecnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ebusy_q <= 1'b1;
        ecnt_q  <= '0;
      end else if (ebusy_q && m_ready_i) begin
        ecnt_q <= ecnt_q + 1'b1;
        if (ecnt_q == lacm_pkg::ROW_LAST) ebusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lacm_pkg::B_IDLE: begin
        if (q_valid_i) begin
          d_q[0] <= q_item_i.dir_x;
          d_q[1] <= q_item_i.dir_y;
          d_q[2] <= q_item_i.dir_z;
          p_q[0] <= q_item_i.pos_x;
          p_q[1] <= q_item_i.pos_y;
          p_q[2] <= q_item_i.pos_z;
          deg_q  <= q_item_i.flat;
        end
      end
      lacm_pkg::B_SIDE: begin
        if (nrsp.done) begin
          s_q[0] <= nrsp.o0;
          s_q[1] <= nrsp.o1;
          s_q[2] <= nrsp.o2;
          cnt_q  <= '0;
        end
      end
      lacm_pkg::B_CROSS: begin
        // products registered, difference taken in the next cycle
        pa_q <= ma1 * mb1;
        pb_q <= ma2 * mb2;
        if (cnt_q != 2'd0) uv_q[cnt_q - 1'b1] <= lacm_pkg::VEC_W'(pa_q - pb_q);
        cnt_q <= cnt_q + 1'b1;
      end
      lacm_pkg::B_UP: begin
        if (nrsp.done) begin
          u_q[0] <= nrsp.o0;
          u_q[1] <= nrsp.o1;
          u_q[2] <= nrsp.o2;
          if (nrsp.zero) deg_q <= 1'b1;
          cnt_q <= lacm_pkg::ROW_SIDE;
        end
      end
      lacm_pkg::B_TPROD: begin
        for (int j = 0; j < 3; j++) tp_q[j] <= rv[j] * p_q[j];
      end
      lacm_pkg::B_TSUM: begin
        acc_q <= -(AccW'(tp_q[0]) + AccW'(tp_q[1]) + AccW'(tp_q[2]));
      end
      lacm_pkg::B_TRND: begin
        t_q[cnt_q] <= round_sat(acc_q);
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
        if (load) begin
          ebuf_q[0] <= '{lacm_pkg::ROW_SIDE, deg_q ? '0 : s_q[0], deg_q ? '0 : s_q[1],
                         deg_q ? '0 : s_q[2], deg_q ? '0 : t_q[0], 1'b0, deg_q};
          ebuf_q[1] <= '{lacm_pkg::ROW_UP, deg_q ? '0 : u_q[0], deg_q ? '0 : u_q[1],
                         deg_q ? '0 : u_q[2], deg_q ? '0 : t_q[1], 1'b0, deg_q};
          ebuf_q[2] <= '{lacm_pkg::ROW_DIR, deg_q ? '0 : sat_neg(d_q[0]),
                         deg_q ? '0 : sat_neg(d_q[1]), deg_q ? '0 : sat_neg(d_q[2]),
                         deg_q ? '0 : t_q[2], 1'b0, deg_q};
          ebuf_q[3] <= '{lacm_pkg::ROW_LAST, '0, '0, '0, lacm_pkg::T_ONE, 1'b1, deg_q};
        end
      end
    endcase
  end

  assign m_valid_o = ebusy_q;
  assign m_row_o   = ebuf_q[ecnt_q];

endmodule

`default_nettype wire

>>> hdl/look_at_camera_matrix.sv
// ----------------------------------------------------------------------------
// look_at_camera_matrix: fixed-point look-at view matrix generator
// ----------------------------------------------------------------------------
// Usage: send one word per camera on the slave stream (direction Q2.14 and
// position Q12.12); the master stream returns four row words, row 0 first,
// with tlast on row 3 and tuser set when the direction is parallel to world
// up (rows 0 to 2 are then zero).
// The back end computes one item at a time: two normalizations on the shared
// normalizer, with k1 and k2 (0 to 30 each) scale steps, each a 31-step
// square root plus three 15-step divides, then the translation terms.
// The four rows leave at one per cycle while the receiver is ready, and the
// next item is already being computed meanwhile.
// The front register and a two-entry queue keep taking words while the back
// end works, so the slave side stalls only when both are full.
// Reset clears all handshake and sequencer state; no rows are pending after
// it. A stalled receiver holds the current row word stable and the back end
// waits on its final step until the row buffer frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module look_at_camera_matrix #(
  parameter int QueueDepth = lacm_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: dir_x, dir_y, dir_z, pos_x, pos_y, pos_z (lowest bit up)
  input  wire logic [lacm_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: row_index, col_zero, col_one, col_two, col_three, zero pad
  output logic [lacm_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic                              m_axis_tlast,
  // tuser: degenerate
  output logic [0:0]                        m_axis_tuser
);

  logic            push, q_ready, q_valid, q_pop;
  lacm_pkg::item_t f_item, q_item;
  lacm_pkg::row_t  row;

  // accept and classify
  lacm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .push_o    (push),
    .item_o    (f_item),
    .q_ready_i (q_ready)
  );

  // decouple front and back
  lacm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // compute and emit rows
  lacm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_row_o   (row)
  );

  // pack the row word
  assign m_axis_tdata = {5'b0, row.col_three, row.col_two, row.col_one,
                         row.col_zero, row.row_index};
  assign m_axis_tlast = row.last_row;
  assign m_axis_tuser = row.degenerate;

endmodule

`default_nettype wire

>>> hdl/lacm_checker.sv
// ----------------------------------------------------------------------------
// lacm_checker: port-level checks of the look-at matrix block
// Row ordering, last marker and constant rows seen on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lacm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [lacm_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic                      m_axis_tlast,
  input wire logic [0:0]                m_axis_tuser
);

  localparam int IdxMsb = lacm_pkg::O_C0_LSB - 1;
  localparam int IdxLsb = lacm_pkg::O_IDX_LSB;

  // hold a stalled word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("row word changed under stall");

  // rows of one item follow back to back in order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid &&
      m_axis_tdata[IdxMsb:IdxLsb] == $past(m_axis_tdata[IdxMsb:IdxLsb]) + 2'd1)
    else $error("row sequence broken");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tlast == (m_axis_tdata[IdxMsb:IdxLsb] == lacm_pkg::ROW_LAST))
    else $error("tlast not on final row");

  a_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[lacm_pkg::O_C3_LSB-1:lacm_pkg::O_C0_LSB] == '0 &&
      m_axis_tdata[lacm_pkg::O_C3_MSB:lacm_pkg::O_C3_LSB] == lacm_pkg::T_ONE)
    else $error("final row not identity");

  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast |->
      m_axis_tdata[lacm_pkg::O_C3_MSB:lacm_pkg::O_C0_LSB] == '0)
    else $error("degenerate row not zero");

endmodule

bind look_at_camera_matrix lacm_checker u_lacm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/look_at_camera_matrix_tb.sv
// ----------------------------------------------------------------------------
// look_at_camera_matrix_tb: self-checking bench for the look-at matrix block
// Feeds camera direction/position words, predicts the four row words of each
// camera in fixed point and compares them in order, under random idling and
// backpressure on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class view_matrix_board;
  typedef struct {
    logic [1:0]  row_index;
    logic [15:0] col_zero;
    logic [15:0] col_one;
    logic [15:0] col_two;
    logic [24:0] col_three;
    logic        last_row;
    logic        degenerate;
  } row_rec_t;

  row_rec_t rows_due[$];
  int       errors;
  int       rows_seen;
  int       cameras;
  int       flat_cameras;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half away from zero, b positive
  function automatic longint round_div(longint a, longint b);
    longint mag, q;
    mag = a < 0 ? -a : a;
    q = (mag + b / 2) / b;
    return a < 0 ? -q : q;
  endfunction

  function automatic bit unit_vec(input longint v0, v1, v2,
                                  output longint o0, o1, o2);
    longint unsigned m;
    longint n, sc;
    int k;
    m = longint'(v0 * v0) + longint'(v1 * v1) + longint'(v2 * v2);
    o0 = 0; o1 = 0; o2 = 0;
    if (m == 0) return 0;
    k = 0;
    while (m < (64'd1 << 60)) begin
      m = m << 2;
      k++;
    end
    n  = longint'(root64(m));
    sc = longint'(1) << (14 + k);
    o0 = clamp(round_div(v0 * sc, n), -32768, 32767);
    o1 = clamp(round_div(v1 * sc, n), -32768, 32767);
    o2 = clamp(round_div(v2 * sc, n), -32768, 32767);
    return 1;
  endfunction

  function automatic longint translation(longint r0, r1, r2, p0, p1, p2);
    return clamp(round_div(-(r0 * p0 + r1 * p1 + r2 * p2), 16384),
                 -16777216, 16777215);
  endfunction

  // Record one accepted camera word and queue its four rows.
  function void note_camera(logic signed [15:0] dx, dy, dz,
                            logic signed [23:0] px, py, pz);
    longint d0, d1, d2, p0, p1, p2, s0, s1, s2, u0, u1, u2;
    longint m [4][4];
    bit flat;
    row_rec_t r;
    d0 = dx; d1 = dy; d2 = dz;
    p0 = px; p1 = py; p2 = pz;
    flat = 0;
    u0 = 0; u1 = 0; u2 = 0;
    if (!unit_vec(-d2, 0, d0, s0, s1, s2)) begin
      flat = 1;
    end else if (!unit_vec(s1 * d2 - s2 * d1, s2 * d0 - s0 * d2,
                           s0 * d1 - s1 * d0, u0, u1, u2)) begin
      flat = 1;
    end
    foreach (m[i, j]) m[i][j] = 0;
    if (!flat) begin
      m[0][0] = s0; m[0][1] = s1; m[0][2] = s2;
      m[1][0] = u0; m[1][1] = u1; m[1][2] = u2;
      // negated -32768 does not fit, clamp the entry but not the dot product
      m[2][0] = clamp(-d0, -32768, 32767);
      m[2][1] = clamp(-d1, -32768, 32767);
      m[2][2] = clamp(-d2, -32768, 32767);
      m[0][3] = translation(s0, s1, s2, p0, p1, p2);
      m[1][3] = translation(u0, u1, u2, p0, p1, p2);
      m[2][3] = translation(-d0, -d1, -d2, p0, p1, p2);
    end
    m[3][3] = 4096;
    for (int i = 0; i < 4; i++) begin
      r.row_index  = i[1:0];
      r.col_zero   = m[i][0][15:0];
      r.col_one    = m[i][1][15:0];
      r.col_two    = m[i][2][15:0];
      r.col_three  = m[i][3][24:0];
      r.last_row   = (i == 3);
      r.degenerate = flat;
      rows_due.push_back(r);
    end
    cameras++;
    if (flat) flat_cameras++;
  endfunction

  // Compare one accepted row word against the oldest queued row.
  function void check_row(logic [79:0] data, logic last, logic user);
    row_rec_t e;
    rows_seen++;
    if (rows_due.size() == 0) begin
      $error("row word with nothing pending: %h", data);
      errors++;
      return;
    end
    e = rows_due.pop_front();
    if (data[1:0] !== e.row_index) begin
      $error("row_index expected %0d got %0d", e.row_index, data[1:0]);
      errors++;
    end
    if (data[17:2] !== e.col_zero) begin
      $error("col_zero expected %h got %h", e.col_zero, data[17:2]);
      errors++;
    end
    if (data[33:18] !== e.col_one) begin
      $error("col_one expected %h got %h", e.col_one, data[33:18]);
      errors++;
    end
    if (data[49:34] !== e.col_two) begin
      $error("col_two expected %h got %h", e.col_two, data[49:34]);
      errors++;
    end
    if (data[74:50] !== e.col_three) begin
      $error("col_three expected %h got %h", e.col_three, data[74:50]);
      errors++;
    end
    if (last !== e.last_row) begin
      $error("last_row expected %0b got %0b", e.last_row, last);
      errors++;
    end
    if (user !== e.degenerate) begin
      $error("degenerate expected %0b got %0b", e.degenerate, user);
      errors++;
    end
  endfunction
endclass

module look_at_camera_matrix_tb;
  localparam int CycleLimit = 1500000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic [0:0]   m_axis_tuser;

  int  tx_idle_pct;
  int  rx_idle_pct;
  logic rx_hold;
  int  cycle_count;
  view_matrix_board board;

  look_at_camera_matrix DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check accepted row words, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_row(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    if (!rst_ni || rx_hold)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d rows pending",
               cycle_count, board.rows_due.size());
      $display("look_at_camera_matrix test failed");
      $finish;
    end
  end

  // Offer one camera word, idling first at random; returns once accepted.
  task automatic send_camera(logic signed [15:0] dx, dy, dz,
                             logic signed [23:0] px, py, pz);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px, dz, dy, dx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_camera(dx, dy, dz, px, py, pz);
  endtask

  task automatic drain_rows();
    s_axis_tvalid <= 1'b0;
    while (board.rows_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_dir(int mode);
    case (mode)
      0:       return 16'(int'($urandom_range(128)) - 64);
      1: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h4000;
          3: return 16'hc000;
          default: return 16'h0001;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(9))
      0:       return 24'h800000;
      1:       return 24'h7fffff;
      2, 3:    return 24'(int'($urandom_range(8192)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly well-formed cameras with random content; some flat or tiny ones.
  task automatic send_random_camera();
    int r, mode;
    logic [15:0] dx, dy, dz;
    r = $urandom_range(99);
    mode = r < 15 ? 0 : (r < 30 ? 1 : 2);
    dx = pick_dir(mode);
    dy = pick_dir(mode);
    dz = pick_dir(mode);
    if (r >= 92) begin
      dx = '0;
      dz = '0;
    end
    send_camera(dx, dy, dz, pick_pos(), pick_pos(), pick_pos());
  endtask

  initial begin
    board = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rx_hold       = 1'b0;
    cycle_count   = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero and world-up directions, axes, extremes of every field
    send_camera(16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_camera(16'sd0, 16'sd16384, 16'sd0, 24'sd4096, 24'sd4096, 24'sd4096);
    send_camera(16'sd0, -16'sd32768, 16'sd0, 24'h7fffff, 24'h800000, 24'sd1);
    send_camera(16'sd16384, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0);
    send_camera(16'sd0, 16'sd0, -16'sd16384, 24'sd8192, -24'sd4096, 24'sd409);
    send_camera(16'sd1, 16'sd0, 16'sd0, 24'sd100, 24'sd200, 24'sd300);
    send_camera(16'sd0, 16'sd0, 16'sd1, -24'sd1, -24'sd1, -24'sd1);
    send_camera(16'sd1, 16'sd32767, 16'sd1, 24'sd5, 24'sd5, 24'sd5);
    send_camera(-16'sd32768, -16'sd32768, -16'sd32768,
                24'h800000, 24'h800000, 24'h800000);
    send_camera(16'sd32767, 16'sd32767, 16'sd32767,
                24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_camera(-16'sd32768, -16'sd32768, -16'sd32768,
                24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_camera(16'sd32767, -16'sd32768, 16'sd32767,
                24'h800000, 24'h7fffff, 24'h800000);
    send_camera(-16'sd32768, 16'sd0, 16'sd32767, 24'h7fffff, 24'sd0, 24'h800000);
    send_camera(16'sd11585, -16'sd8192, -16'sd11585, 24'sd40960, 24'sd0, -24'sd40960);
    send_camera(-16'sd1, 16'sd0, -16'sd1, 24'h555555, 24'haaaaaa, 24'h0f0f0f);
    send_camera(16'sd2, -16'sd32768, -16'sd3, 24'sd12, 24'sd34, 24'sd56);
    send_camera(16'h5555, 16'haaaa, 16'h0f0f, 24'h123456, 24'hedcba9, 24'h000fff);
    send_camera(16'haaaa, 16'h5555, 16'hf0f0, 24'hfff000, 24'h0, 24'h7ff800);
    drain_rows();

    tx_idle_pct = 15;
    rx_idle_pct = 84;
    repeat (130) send_random_camera();
    drain_rows();

    tx_idle_pct = 84;
    rx_idle_pct = 15;
    repeat (130) send_random_camera();
    drain_rows();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // stall the row side long enough for the input queue to back up
    fork
      begin
        rx_hold <= 1'b1;
        repeat (4000) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (12) send_random_camera();
    drain_rows();
    repeat (120) send_random_camera();
    s_axis_tvalid <= 1'b0;

    while (board.rows_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("covered %0d cameras (%0d flat to world up), %0d row words checked",
             board.cameras, board.flat_cameras, board.rows_seen);
    $display("streams ran with random idling on each side and a long row stall");
    if (board.errors == 0 && board.rows_due.size() == 0) begin
      $display("look_at_camera_matrix test passed");
    end else begin
      $display("look_at_camera_matrix test failed");
    end
    $finish;
  end
endmodule
